// ===== rtl/core/sfd_pkg.sv =====
// Shared constants, codes and arithmetic helpers for the stereo feedback delay.
package sfd_pkg;

    // Delay store geometry (power-of-two depth, pointer wraps naturally)
    localparam int unsigned DEPTH    = 131072;
    localparam int unsigned ADDR_W   = $clog2(DEPTH);
    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned DELAY_W  = 17;
    localparam int unsigned CFG_W    = 17;
    localparam int unsigned CFG_IDX_W = 3;

    // Product of a 17-bit signed gain and a 25-bit signed sample
    localparam int unsigned PROD_W   = 42;
    localparam int unsigned ACC_W    = 43;
    localparam int unsigned RND_W    = ACC_W - 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET_LEFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd4;

    // Register reset values
    localparam logic [DELAY_W-1:0] DELAY_RST = 17'd6240;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd23170;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [GAIN_W-1:0]          t_gain;
    typedef logic [ADDR_W-1:0]          t_addr;

    // Q1.15 rounding, half toward plus infinity
    function automatic logic signed [RND_W-1:0] round_q15(input logic signed [ACC_W-1:0] p);
        logic signed [ACC_W-1:0] t;
        t = p + 43'sd16384;
        return t[ACC_W-1:15];
    endfunction

    // Clamp to the 24-bit sample range
    function automatic t_sample sat24(input logic signed [RND_W:0] v);
        if (v > 29'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -29'sd8388608) begin
            return 24'sh800000;
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/stereo_feedback_delay_unit.sv =====
// Stereo feedback delay line with a shared multiplier and a small sequencer.
//
// Takes one stereo pair per request and returns one mixed stereo pair. Each
// pair goes through these steps from one acceptance to the earliest next one:
// acceptance, which reads both delay stores; six steps per channel
// through the single 17x25 multiplier (dry, wet, sum, round, feedback, write
// back); and a step to load the output register. That last step holds for
// as long as the previous result still waits unread on the master side, so a
// slow master side adds its stall cycles. The output register lets the next
// pair be taken while a result still waits on the master side. No clearing
// pass is needed after reset: a wrap flag and the write pointer tell which
// store entries were ever written, and entries never written read as zero.
module stereo_feedback_delay_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: [23:0] left_in, [47:24] right_in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,
    // Master side: [23:0] left_out, [47:24] right_out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,
    // Configuration write port
    input  logic                        i_cfg_wr_en,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfd_pkg::CFG_W-1:0]   i_cfg_data
);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DRY  = 3'd1;
    localparam logic [2:0] ST_WET  = 3'd2;
    localparam logic [2:0] ST_MIX  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_FB   = 3'd5;
    localparam logic [2:0] ST_WR   = 3'd6;
    localparam logic [2:0] ST_PUSH = 3'd7;

    // Configuration registers
    logic [sfd_pkg::DELAY_W-1:0] r_delay;
    sfd_pkg::t_gain              r_dry, r_wet_l, r_wet_r, r_fb;

    // Control state
    logic [2:0]      r_state, n_state;
    logic            r_ch;
    sfd_pkg::t_addr  r_wp;
    logic            r_full;
    logic            r_zero_dly;
    logic            r_dvalid;
    logic            r_out_valid;

    // Datapath registers
    sfd_pkg::t_sample r_xl, r_xr, r_yl, r_yr, r_rd_l, r_rd_r;
    logic signed [sfd_pkg::PROD_W-1:0] r_prod;
    logic signed [sfd_pkg::ACC_W-1:0]  r_acc;
    logic [47:0]                        r_out_data;

    // Delay stores
    sfd_pkg::t_sample mem_l [sfd_pkg::DEPTH];
    sfd_pkg::t_sample mem_r [sfd_pkg::DEPTH];

    logic             in_acc;
    logic             push_ok;
    sfd_pkg::t_addr   rd_addr;
    sfd_pkg::t_sample cur_x, cur_rd, cur_dly, cur_y, wr_data;
    sfd_pkg::t_gain   cur_wet;
    logic signed [16:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [sfd_pkg::PROD_W-1:0] mul_p;
    logic signed [sfd_pkg::ACC_W-1:0]  mix_sum;
    logic signed [sfd_pkg::RND_W:0]    fb_sum;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign push_ok         = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Read address trails the write pointer by the delay
    assign rd_addr = r_wp - sfd_pkg::t_addr'(r_delay);

    // Per-channel operand selection
    assign cur_x   = r_ch ? r_xr : r_xl;
    assign cur_rd  = r_ch ? r_rd_r : r_rd_l;
    assign cur_wet = r_ch ? r_wet_r : r_wet_l;
    assign cur_y   = r_ch ? r_yr : r_yl;
    assign cur_dly = r_zero_dly ? cur_x : (r_dvalid ? cur_rd : '0);

    // Shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DRY: begin
                mul_a = signed'({1'b0, r_dry});
                mul_b = 25'(cur_x);
            end
            ST_WET: begin
                mul_a = signed'({1'b0, cur_wet});
                mul_b = 25'(cur_dly);
            end
            ST_FB: begin
                mul_a = signed'({1'b0, r_fb});
                mul_b = 25'(cur_y);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign mix_sum = r_acc + sfd_pkg::ACC_W'(r_prod);
    assign fb_sum  = 29'(cur_x) + 29'(sfd_pkg::round_q15(sfd_pkg::ACC_W'(r_prod)));
    assign wr_data = sfd_pkg::sat24(fb_sum);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_DRY;
            ST_DRY:  n_state = ST_WET;
            ST_WET:  n_state = ST_MIX;
            ST_MIX:  n_state = ST_OUT;
            ST_OUT:  n_state = ST_FB;
            ST_FB:   n_state = ST_WR;
            ST_WR:   n_state = r_ch ? ST_PUSH : ST_DRY;
            ST_PUSH: if (push_ok) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= 1'b0;
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
            r_delay     <= sfd_pkg::DELAY_RST;
            r_dry       <= sfd_pkg::GAIN_RST;
            r_wet_l     <= sfd_pkg::GAIN_RST;
            r_wet_r     <= sfd_pkg::GAIN_RST;
            r_fb        <= sfd_pkg::GAIN_RST;
        end else begin
            r_state <= n_state;
            if (r_state == ST_WR) r_ch <= ~r_ch;
            // output register: loads at the end of a pair, else drains on take
            if (r_state == ST_PUSH && push_ok) begin
                r_out_valid <= 1'b1;
                r_wp        <= r_wp + 1'b1;
                if (r_wp == sfd_pkg::t_addr'(sfd_pkg::DEPTH - 1)) r_full <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    sfd_pkg::REG_DELAY:     r_delay <= i_cfg_data;
                    sfd_pkg::REG_DRY:       r_dry   <= i_cfg_data[sfd_pkg::GAIN_W-1:0];
                    sfd_pkg::REG_WET_LEFT:  r_wet_l <= i_cfg_data[sfd_pkg::GAIN_W-1:0];
                    sfd_pkg::REG_WET_RIGHT: r_wet_r <= i_cfg_data[sfd_pkg::GAIN_W-1:0];
                    sfd_pkg::REG_FEEDBACK:  r_fb    <= i_cfg_data[sfd_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_xl       <= i_s_axis_tdata[23:0];
            r_xr       <= i_s_axis_tdata[47:24];
            r_zero_dly <= (r_delay == '0);
            r_dvalid   <= r_full || (rd_addr < r_wp);
        end
        case (r_state)
            ST_DRY: r_prod <= mul_p;
            ST_WET: begin
                r_acc  <= sfd_pkg::ACC_W'(r_prod);
                r_prod <= mul_p;
            end
            ST_MIX: r_acc <= mix_sum;
            ST_OUT: begin
                if (r_ch) r_yr <= sfd_pkg::sat24(29'(sfd_pkg::round_q15(r_acc)));
                else      r_yl <= sfd_pkg::sat24(29'(sfd_pkg::round_q15(r_acc)));
            end
            ST_FB: r_prod <= mul_p;
            default: ;
        endcase
        if (r_state == ST_PUSH && push_ok) r_out_data <= {r_yr, r_yl};
    end

    // Delay stores: read at acceptance, written back once per channel
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WR && !r_ch) mem_l[r_wp] <= wr_data;
        if (in_acc) r_rd_l <= mem_l[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WR && r_ch) mem_r[r_wp] <= wr_data;
        if (in_acc) r_rd_r <= mem_r[rd_addr];
    end

    // An accepted pair keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input side ready right after an accepted request");

    // Write pointer steps by one with each new result
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_wp == sfd_pkg::t_addr'($past(r_wp) + 1'b1)))
        else $error("write pointer did not advance with the result");

    // Once the store has wrapped it stays fully written
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("wrap flag dropped without reset");

    // Channel select is back on left whenever the sequencer is idle
    a_ch_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_ch)
        else $error("channel select not on left while idle");

endmodule
